// ===== hdl/mag_hdg_pkg.sv =====
package mag_hdg_pkg;

    localparam int FIELD_W       = 16;
    localparam int HDG_W         = 9;
    localparam int IN_TDATA_W    = 48;
    localparam int OUT_TDATA_W   = 64;
    localparam int TABLE_LEN     = 24;
    localparam int PRESCALE_BITS = 24;

    localparam logic [HDG_W-1:0] HDG_0   = 9'd0;
    localparam logic [HDG_W-1:0] HDG_45  = 9'd45;
    localparam logic [HDG_W-1:0] HDG_90  = 9'd90;
    localparam logic [HDG_W-1:0] HDG_135 = 9'd135;
    localparam logic [HDG_W-1:0] HDG_180 = 9'd180;
    localparam logic [HDG_W-1:0] HDG_225 = 9'd225;
    localparam logic [HDG_W-1:0] HDG_270 = 9'd270;
    localparam logic [HDG_W-1:0] HDG_315 = 9'd315;
    localparam logic [HDG_W-1:0] HDG_MAX = 9'd359;

    // atan(2^-i) in degrees, units of 2^-24 degree
    localparam longint ATAN_DEG_Q24 [TABLE_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    // angle rounded half up to frac bits if frac <= 24
    function automatic longint stage_angle(int idx, int frac);
        longint t;
        int     sh;
        sh = PRESCALE_BITS - frac;
        t  = ATAN_DEG_Q24[idx];
        if (sh <= 0) begin
            return t;
        end
        return (t + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

endpackage

// ===== hdl/magnetometer_heading.sv =====
// pipeline: an assembly stage, the micro-rotation stages and an output stage,
// from input request to result
// throughput: one burst per cycle while the output is not stalled; each stage holds or
// moves on its own, so bubbles close up and a stalled output stops only the full stages behind it
// reset: synchronous, active low, clears every stage valid bit; payload is not reset
module magnetometer_heading #(
    parameter int CORDIC_STAGES       = 16,
    parameter int ANGLE_FRACTION_BITS = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // x_high, x_low, z_high, z_low, y_high, y_low
    input  logic [mag_hdg_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    // burst_complete
    input  logic                                   i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // heading_degrees, field_x, field_y, field_z, zero padding
    output logic [mag_hdg_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int N   = CORDIC_STAGES;
    localparam int F   = ANGLE_FRACTION_BITS;
    localparam int FW  = mag_hdg_pkg::FIELD_W;
    localparam int HW  = mag_hdg_pkg::HDG_W;
    localparam int PB  = mag_hdg_pkg::PRESCALE_BITS;
    localparam int XW  = FW + PB + 3;
    localparam int ZW  = F + 11;
    localparam int S   = N + 2;
    localparam int PAD = mag_hdg_pkg::OUT_TDATA_W - HW - 3 * FW;

    localparam logic signed [ZW-1:0] Z_HALF = ZW'(longint'(180) << F);
    localparam logic signed [ZW-1:0] Z_FULL = ZW'(longint'(360) << F);

    logic [S-1:0] en;
    logic         r_vld [0:S-1];

    logic signed [XW-1:0] r_x  [0:N];
    logic signed [XW-1:0] r_y  [0:N];
    logic signed [ZW-1:0] r_z  [0:N];
    logic signed [FW-1:0] r_fx [0:N];
    logic signed [FW-1:0] r_fy [0:N];
    logic signed [FW-1:0] r_fz [0:N];
    logic                 r_sp [0:N];
    logic [HW-1:0]        r_sh [0:N];

    logic [HW-1:0]        r_o_hdg;
    logic signed [FW-1:0] r_o_fx;
    logic signed [FW-1:0] r_o_fy;
    logic signed [FW-1:0] r_o_fz;

    // stage enables, a stage moves on when empty or when its successor moves
    always_comb begin
        en[S-1] = !r_vld[S-1] || i_m_tready;
        for (int k = S - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[0];

    // assembly stage
    logic signed [FW-1:0] n_fx;
    logic signed [FW-1:0] n_fy;
    logic signed [FW-1:0] n_fz;
    logic signed [FW:0]   fx_e;
    logic signed [FW:0]   fy_neg;
    logic signed [XW-1:0] x_pre;
    logic signed [XW-1:0] y_pre;
    logic signed [XW-1:0] n_x0;
    logic signed [XW-1:0] n_y0;
    logic signed [ZW-1:0] n_z0;
    logic                 n_sp;
    logic [HW-1:0]        n_sh;

    always_comb begin
        n_fx   = {i_s_tdata[7:0],   i_s_tdata[15:8]};
        n_fz   = {i_s_tdata[23:16], i_s_tdata[31:24]};
        n_fy   = {i_s_tdata[39:32], i_s_tdata[47:40]};
        fx_e   = {n_fx[FW-1], n_fx};
        fy_neg = -{n_fy[FW-1], n_fy};
        x_pre  = {{(XW-FW-PB){n_fx[FW-1]}}, n_fx, {PB{1'b0}}};
        y_pre  = {{(XW-FW-PB){n_fy[FW-1]}}, n_fy, {PB{1'b0}}};
        if (n_fx[FW-1]) begin
            n_x0 = -x_pre;
            n_y0 = -y_pre;
            n_z0 = Z_HALF;
        end else begin
            n_x0 = x_pre;
            n_y0 = y_pre;
            n_z0 = '0;
        end
        n_sp = 1'b1;
        priority if (n_fy == '0) begin
            n_sh = n_fx[FW-1] ? mag_hdg_pkg::HDG_180 : mag_hdg_pkg::HDG_0;
        end else if (n_fx == '0) begin
            n_sh = n_fy[FW-1] ? mag_hdg_pkg::HDG_270 : mag_hdg_pkg::HDG_90;
        end else if (n_fx == n_fy) begin
            n_sh = n_fx[FW-1] ? mag_hdg_pkg::HDG_225 : mag_hdg_pkg::HDG_45;
        end else if (fx_e == fy_neg) begin
            n_sh = n_fx[FW-1] ? mag_hdg_pkg::HDG_135 : mag_hdg_pkg::HDG_315;
        end else begin
            n_sp = 1'b0;
            n_sh = mag_hdg_pkg::HDG_0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (en[0]) begin
            r_vld[0] <= i_s_tvalid && i_s_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_x[0]  <= n_x0;
            r_y[0]  <= n_y0;
            r_z[0]  <= n_z0;
            r_fx[0] <= n_fx;
            r_fy[0] <= n_fy;
            r_fz[0] <= n_fz;
            r_sp[0] <= n_sp;
            r_sh[0] <= n_sh;
        end
    end

    // micro-rotations
    for (genvar k = 0; k < N; k++) begin : g_stage
        localparam logic signed [ZW-1:0] ANG = ZW'(mag_hdg_pkg::stage_angle(k, F));

        logic                 y_pos;
        logic signed [XW-1:0] n_x;
        logic signed [XW-1:0] n_y;
        logic signed [ZW-1:0] n_z;

        always_comb begin
            y_pos = !r_y[k][XW-1] && (r_y[k] != '0);
            if (y_pos) begin
                n_x = r_x[k] + (r_y[k] >>> k);
                n_y = r_y[k] - (r_x[k] >>> k);
                n_z = r_z[k] + ANG;
            end else begin
                n_x = r_x[k] - (r_y[k] >>> k);
                n_y = r_y[k] + (r_x[k] >>> k);
                n_z = r_z[k] - ANG;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k+1] <= 1'b0;
            end else if (en[k+1]) begin
                r_vld[k+1] <= r_vld[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[k+1]) begin
                r_x[k+1]  <= n_x;
                r_y[k+1]  <= n_y;
                r_z[k+1]  <= n_z;
                r_fx[k+1] <= r_fx[k];
                r_fy[k+1] <= r_fy[k];
                r_fz[k+1] <= r_fz[k];
                r_sp[k+1] <= r_sp[k];
                r_sh[k+1] <= r_sh[k];
            end
        end
    end

    // range move and truncation
    logic signed [ZW-1:0] z_a;
    logic signed [ZW-1:0] z_b;
    logic [HW-1:0]        n_hdg;

    always_comb begin
        z_a = r_z[N][ZW-1] ? r_z[N] + Z_FULL : r_z[N];
        z_b = (z_a >= Z_FULL) ? z_a - Z_FULL : z_a;
        if (z_b[ZW-1]) begin
            z_b = '0;
        end
        n_hdg = r_sp[N] ? r_sh[N] : z_b[F+HW-1:F];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[S-1] <= 1'b0;
        end else if (en[S-1]) begin
            r_vld[S-1] <= r_vld[N];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[S-1]) begin
            r_o_hdg <= n_hdg;
            r_o_fx  <= r_fx[N];
            r_o_fy  <= r_fy[N];
            r_o_fz  <= r_fz[N];
        end
    end

    assign o_m_tvalid = r_vld[S-1];
    assign o_m_tdata  = {{PAD{1'b0}}, r_o_fz, r_o_fy, r_o_fx, r_o_hdg};

endmodule

// ===== hdl/mag_hdg_checker.sv =====
module mag_hdg_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                o_m_tvalid,
    input logic                                i_m_tready,
    input logic [mag_hdg_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    logic [mag_hdg_pkg::HDG_W-1:0] hdg;
    logic [15:0]                   fx;
    logic [15:0]                   fy;

    assign hdg = o_m_tdata[8:0];
    assign fx  = o_m_tdata[24:9];
    assign fy  = o_m_tdata[40:25];

    a_rst_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_hdg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> hdg <= mag_hdg_pkg::HDG_MAX)
        else $error("heading beyond 359");

    a_y_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && fy == '0 |->
            hdg == (fx[15] ? mag_hdg_pkg::HDG_180 : mag_hdg_pkg::HDG_0))
        else $error("heading wrong on the x axis");

    a_x_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && fx == '0 && fy != '0 |->
            hdg == (fy[15] ? mag_hdg_pkg::HDG_270 : mag_hdg_pkg::HDG_90))
        else $error("heading wrong on the y axis");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

endmodule

bind magnetometer_heading mag_hdg_checker u_mag_hdg_checker (.*);

// ===== dv/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STAGES = 16;
    localparam int FRAC   = 16;
    localparam int ATAN_LEN = 24;
    localparam int PRE_SHIFT = 24;
    localparam int HDG_BITS  = mag_hdg_pkg::HDG_W;

    typedef struct {
        bit          complete;
        logic [15:0] x;
        logic [15:0] z;
        logic [15:0] y;
    } t_burst;

    typedef struct {
        logic [mag_hdg_pkg::HDG_W-1:0]   heading;
        logic [mag_hdg_pkg::FIELD_W-1:0] x;
        logic [mag_hdg_pkg::FIELD_W-1:0] y;
        logic [mag_hdg_pkg::FIELD_W-1:0] z;
    } t_heading;

    // atan(2^-i) in degrees, units of 2^-24 degree
    localparam longint ATAN_Q24 [ATAN_LEN] = '{
        754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
        15018523, 7509720, 3754917, 1877466, 938734, 469367,
        234684, 117342, 58671, 29335, 14668, 7334,
        3667, 1833, 917, 458, 229, 115
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [mag_hdg_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
    logic                                s_tuser = 1'b0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [mag_hdg_pkg::OUT_TDATA_W-1:0] m_tdata;

    t_burst   bursts[$];
    t_heading pending_headings[$];
    bit       req_taken = 1'b0;
    int       errors = 0;
    int       cycle = 0;
    bit       calm;

    magnetometer_heading #(
        .CORDIC_STAGES      (STAGES),
        .ANGLE_FRACTION_BITS(FRAC)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        .i_s_tdata (s_tdata),
        .i_s_tuser (s_tuser),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .o_m_tdata (m_tdata)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [mag_hdg_pkg::HDG_W-1:0] compass_heading(input longint fx,
                                                                      input longint fy);
        longint one;
        longint full;
        longint vx;
        longint vy;
        longint ang;
        longint sx;
        longint sy;
        longint step;
        int     sh;
        int     n;
        one  = longint'(1) << FRAC;
        full = 360 * one;
        sh   = PRE_SHIFT - FRAC;
        if (fy == 0) begin
            return (fx < 0) ? mag_hdg_pkg::HDG_180 : mag_hdg_pkg::HDG_0;
        end
        if (fx == 0) begin
            return (fy > 0) ? mag_hdg_pkg::HDG_90 : mag_hdg_pkg::HDG_270;
        end
        if (fx == fy) begin
            return (fx > 0) ? mag_hdg_pkg::HDG_45 : mag_hdg_pkg::HDG_225;
        end
        if (fx == -fy) begin
            return (fx > 0) ? mag_hdg_pkg::HDG_315 : mag_hdg_pkg::HDG_135;
        end
        vx  = fx <<< PRE_SHIFT;
        vy  = fy <<< PRE_SHIFT;
        ang = 0;
        // left half plane: mirror through the origin and start from 180
        if (vx < 0) begin
            vx  = -vx;
            vy  = -vy;
            ang = 180 * one;
        end
        n = (STAGES > ATAN_LEN) ? ATAN_LEN : STAGES;
        for (int i = 0; i < n; i++) begin
            sx   = vx >>> i;
            sy   = vy >>> i;
            step = (sh <= 0) ? ATAN_Q24[i]
                             : (ATAN_Q24[i] + (longint'(1) << (sh - 1))) >>> sh;
            if (vy > 0) begin
                vx  = vx + sy;
                vy  = vy - sx;
                ang = ang + step;
            end else begin
                vx  = vx - sy;
                vy  = vy + sx;
                ang = ang - step;
            end
        end
        if (ang < 0) begin
            ang = ang + full;
        end
        if (ang >= full) begin
            ang = ang - full;
        end
        if (ang < 0) begin
            ang = 0;
        end
        return HDG_BITS'(ang >>> FRAC);
    endfunction

    task automatic add_burst(input bit complete, input int ax, input int az, input int ay);
        t_burst b;
        b.complete = complete;
        b.x        = ax[15:0];
        b.z        = az[15:0];
        b.y        = ay[15:0];
        bursts.push_back(b);
    endtask

    function automatic int rand_axis();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            return $urandom_range(0, 65535);
        end else if (pick < 70) begin
            return $urandom_range(0, 511) - 256;
        end else if (pick < 85) begin
            unique case ($urandom_range(0, 4))
                0: return -32768;
                1: return 32767;
                2: return -1;
                3: return 1;
                default: return 0;
            endcase
        end
        return $urandom_range(0, 8191) - 4096;
    endfunction

    // acceptance, prediction and result checking
    always @(posedge i_clk) begin
        t_heading got;
        t_heading want;
        longint   fx;
        longint   fy;
        cycle <= cycle + 1;
        req_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n && s_tvalid && s_tready && s_tuser) begin
            want.x       = {s_tdata[7:0], s_tdata[15:8]};
            want.z       = {s_tdata[23:16], s_tdata[31:24]};
            want.y       = {s_tdata[39:32], s_tdata[47:40]};
            fx           = longint'(signed'(want.x));
            fy           = longint'(signed'(want.y));
            want.heading = compass_heading(fx, fy);
            pending_headings.push_back(want);
        end
        if (i_rst_n && m_tvalid && m_tready) begin
            got.heading = m_tdata[8:0];
            got.x       = m_tdata[24:9];
            got.y       = m_tdata[40:25];
            got.z       = m_tdata[56:41];
            if (pending_headings.size() == 0) begin
                $display("%0t: unexpected result heading %0d x %0d y %0d z %0d", $time,
                         got.heading, signed'(got.x), signed'(got.y), signed'(got.z));
                errors++;
            end else begin
                want = pending_headings.pop_front();
                if (got.heading !== want.heading) begin
                    $display("%0t: heading expected %0d actual %0d", $time,
                             want.heading, got.heading);
                    errors++;
                end
                if (got.x !== want.x) begin
                    $display("%0t: field_x expected %0d actual %0d", $time,
                             signed'(want.x), signed'(got.x));
                    errors++;
                end
                if (got.y !== want.y) begin
                    $display("%0t: field_y expected %0d actual %0d", $time,
                             signed'(want.y), signed'(got.y));
                    errors++;
                end
                if (got.z !== want.z) begin
                    $display("%0t: field_z expected %0d actual %0d", $time,
                             signed'(want.z), signed'(got.z));
                    errors++;
                end
            end
        end
    end

    // no idling in the middle stretch of the run
    assign calm = (cycle >= 400) && (cycle < 700);

    // request driver
    always @(negedge i_clk) begin
        t_burst b;
        if (i_rst_n && (!s_tvalid || req_taken)) begin
            if (bursts.size() != 0 && (calm || $urandom_range(0, 99) >= 18)) begin
                b = bursts.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= b.complete;
                s_tdata  <= {b.y[7:0], b.y[15:8], b.z[7:0], b.z[15:8], b.x[7:0], b.x[15:8]};
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end

    initial begin
        int ax;
        int pick;
        add_burst(1, 0, 0, 0);
        add_burst(1, 1000, 5, 0);
        add_burst(1, -1000, 5, 0);
        add_burst(1, 0, 7, 1000);
        add_burst(1, 0, 7, -1000);
        add_burst(1, 500, 0, 500);
        add_burst(1, -500, 0, -500);
        add_burst(1, 500, 0, -500);
        add_burst(1, -500, 0, 500);
        add_burst(1, 32767, -32768, -1);
        add_burst(1, -32768, 32767, -32768);
        add_burst(1, -32768, 0, 32767);
        add_burst(1, 32767, 0, 32767);
        add_burst(1, -32768, 0, 1);
        add_burst(1, -32768, 0, -1);
        add_burst(1, 1, 0, -32768);
        add_burst(1, -1, 0, 32767);
        add_burst(0, -1, -1, -1);
        add_burst(0, 0, 0, 0);
        add_burst(1, -1, -1, -1);
        add_burst(1, 12345, -4321, -23456);
        add_burst(1, -7, 3, 2);
        add_burst(1, 32767, 32767, -32767);
        for (int i = 0; i < 900; i++) begin
            ax   = rand_axis();
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                add_burst($urandom_range(0, 99) >= 12, ax, $urandom_range(0, 65535), ax);
            end else if (pick < 15) begin
                add_burst($urandom_range(0, 99) >= 12, ax, $urandom_range(0, 65535), -ax);
            end else if (pick < 22) begin
                add_burst($urandom_range(0, 99) >= 12, ax, $urandom_range(0, 65535), 0);
            end else if (pick < 28) begin
                add_burst($urandom_range(0, 99) >= 12, 0, $urandom_range(0, 65535), ax);
            end else begin
                add_burst($urandom_range(0, 99) >= 12, ax, $urandom_range(0, 65535),
                          rand_axis());
            end
        end
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (bursts.size() != 0 || s_tvalid) begin
            @(posedge i_clk);
        end
        while (pending_headings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (STAGES + 10) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("%0t: timeout", $time);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
